// ===== src/ssh_kex_pkg.sv =====
`timescale 1ns / 1ps

package ssh_kex_pkg;

   // field widths
   localparam int unsigned DataWidth      = 8;
   localparam int unsigned MaxLenWidth    = 16;
   localparam int unsigned VerdictWidth   = 2;
   localparam int unsigned ListCountWidth = 4;

   // defaults
   localparam logic [MaxLenWidth-1:0] MaxPacketLenReset = 16'd35000;
   localparam int unsigned            NameListCountDefault = 10;

   // message codes
   localparam logic [DataWidth-1:0] MsgKexinit = 8'd20;
   localparam logic [DataWidth-1:0] MsgIgnore  = 8'd2;

   // verdict codes
   typedef enum logic [VerdictWidth-1:0] {
      VERDICT_PENDING = 2'd0,
      VERDICT_MATCH   = 2'd1,
      VERDICT_NOMATCH = 2'd2,
      VERDICT_IGNORED = 2'd3
   } verdict_type;

   // one stream byte with its segment marker
   typedef struct packed {
      logic                 segment_end;
      logic [DataWidth-1:0] data_byte;
   } req_item_type;

endpackage

// ===== src/ssh_kex_in_stage.sv =====
`timescale 1ns / 1ps

module ssh_kex_in_stage (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  ssh_kex_pkg::req_item_type  req_item,
   input  logic                       down_ready,
   output logic                       step_en,
   output ssh_kex_pkg::req_item_type  item
);
   import ssh_kex_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;

   // the held request moves on when the result side has room
   assign step_en   = valid_ff && down_ready;
   assign req_ready = !valid_ff || down_ready;
   assign item      = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (req_ready) begin
         valid_in = req_valid;
      end else if (step_en) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // request payload
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_item;
      end
   end

endmodule

// ===== src/ssh_kex_parser.sv =====
`timescale 1ns / 1ps

module ssh_kex_parser #(
   parameter int unsigned NAME_LIST_COUNT = ssh_kex_pkg::NameListCountDefault
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    step_en,
   input  ssh_kex_pkg::req_item_type               item,
   input  logic [ssh_kex_pkg::MaxLenWidth-1:0]     max_packet_len,
   output ssh_kex_pkg::verdict_type                verdict
);
   import ssh_kex_pkg::*;

   typedef enum logic [3:0] {
      PH_LEN       = 4'd0,
      PH_PAD       = 4'd1,
      PH_CODE      = 4'd2,
      PH_IGNORE    = 4'd3,
      PH_COOKIE    = 4'd4,
      PH_LIST_LEN  = 4'd5,
      PH_LIST_DATA = 4'd6,
      PH_TAIL      = 4'd7,
      PH_PADDING   = 4'd8
   } phase_type;

   localparam logic [15:0] CookieBytes = 16'd16;
   localparam logic [ListCountWidth-1:0] ListLast = ListCountWidth'(NAME_LIST_COUNT);

   phase_type                 phase_ff, phase_in;
   logic [15:0]               pos_ff, pos_in;
   logic [31:0]               length_ff, length_in;
   logic [15:0]               total_ff, total_in;
   logic [7:0]                pad_ff, pad_in;
   logic [15:0]               list_len_ff, list_len_in;
   logic [ListCountWidth-1:0] list_count_ff, list_count_in;
   logic [16:0]               acc_ff, acc_in;
   logic                      decided_ff, decided_in;

   logic [15:0]               pos_inc;
   logic [31:0]               shifted;
   logic [ListCountWidth-1:0] count_inc;
   phase_type                 after_list;
   logic                      oversize;
   logic [17:0]               list_sum;
   logic                      overrun;

   // shared per-byte terms
   always_comb begin
      pos_inc    = pos_ff + 16'd1;
      shifted    = {length_ff[23:0], item.data_byte};
      count_inc  = list_count_ff + 1'b1;
      after_list = (count_inc >= ListLast) ? PH_TAIL : PH_LIST_LEN;
      // packet length plus the four length bytes against the limit
      oversize   = (length_ff[31:16] != 16'd0) ||
                   (({1'b0, length_ff[15:0]} + 17'd4) > {1'b0, max_packet_len});
      // running total of header, cookie and lists against packet length
      list_sum   = {1'b0, acc_ff} + {2'b00, shifted[15:0]} + 18'd4;
      overrun    = (shifted[31:16] != 16'd0) || (list_sum > {2'b00, total_ff});
   end

   // one step of the packet walk
   always_comb begin
      phase_in      = phase_ff;
      pos_in        = pos_ff;
      length_in     = length_ff;
      total_in      = total_ff;
      pad_in        = pad_ff;
      list_len_in   = list_len_ff;
      list_count_in = list_count_ff;
      acc_in        = acc_ff;
      verdict       = VERDICT_PENDING;

      if (decided_ff) begin
         verdict = VERDICT_IGNORED;
      end else begin
         case (phase_ff)
            PH_LEN: begin
               length_in = shifted;
               pos_in    = pos_inc;
               if (pos_inc >= 16'd4) begin
                  phase_in = PH_PAD;
               end
            end
            PH_PAD: begin
               pad_in   = item.data_byte;
               pos_in   = pos_inc;
               phase_in = PH_CODE;
            end
            PH_CODE: begin
               total_in = length_ff[15:0] + 16'd4;
               if (item.data_byte == MsgKexinit) begin
                  pos_in   = 16'd0;
                  phase_in = PH_COOKIE;
                  acc_in   = {9'd0, pad_ff} + 17'd20;
                  if (oversize) begin
                     verdict = VERDICT_NOMATCH;
                  end
               end else if (item.data_byte == MsgIgnore) begin
                  pos_in   = 16'd6;
                  phase_in = PH_IGNORE;
                  if (oversize) begin
                     verdict = VERDICT_NOMATCH;
                  end
               end else begin
                  verdict = VERDICT_NOMATCH;
               end
            end
            PH_IGNORE: begin
               pos_in = pos_inc;
               if (pos_inc >= total_ff) begin
                  phase_in = PH_LEN;
                  pos_in   = 16'd0;
               end
            end
            PH_COOKIE: begin
               pos_in = pos_inc;
               if (pos_inc >= CookieBytes) begin
                  phase_in = PH_LIST_LEN;
                  pos_in   = 16'd0;
               end
            end
            PH_LIST_LEN: begin
               length_in = shifted;
               pos_in    = pos_inc;
               if (pos_inc >= 16'd4) begin
                  pos_in = 16'd0;
                  if (overrun) begin
                     verdict = VERDICT_NOMATCH;
                  end else begin
                     acc_in      = list_sum[16:0];
                     list_len_in = shifted[15:0];
                     if (shifted[15:0] != 16'd0) begin
                        phase_in = PH_LIST_DATA;
                     end else begin
                        list_count_in = count_inc;
                        phase_in      = after_list;
                     end
                  end
               end
            end
            PH_LIST_DATA: begin
               pos_in = pos_inc;
               if (pos_inc >= list_len_ff) begin
                  list_count_in = count_inc;
                  pos_in        = 16'd0;
                  phase_in      = after_list;
               end
            end
            PH_TAIL: begin
               // kex-follows flag first, then the reserved word
               if (pos_ff >= 16'd1) begin
                  length_in = shifted;
               end
               pos_in = pos_inc;
               if (pos_inc >= 16'd5) begin
                  if (shifted != 32'd0) begin
                     verdict = VERDICT_NOMATCH;
                  end else begin
                     phase_in = PH_PADDING;
                     pos_in   = 16'd0;
                  end
               end
            end
            PH_PADDING: begin
               pos_in = pos_inc;
               if (pos_inc >= {8'd0, pad_ff}) begin
                  verdict = item.segment_end ? VERDICT_MATCH : VERDICT_NOMATCH;
               end
            end
            default: begin
               verdict = VERDICT_NOMATCH;
            end
         endcase
      end

      decided_in = decided_ff || (verdict != VERDICT_PENDING);
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_LEN;
         pos_ff        <= 16'd0;
         length_ff     <= 32'd0;
         total_ff      <= 16'd0;
         pad_ff        <= 8'd0;
         list_len_ff   <= 16'd0;
         list_count_ff <= '0;
         acc_ff        <= 17'd0;
         decided_ff    <= 1'b0;
      end else if (step_en) begin
         phase_ff      <= phase_in;
         pos_ff        <= pos_in;
         length_ff     <= length_in;
         total_ff      <= total_in;
         pad_ff        <= pad_in;
         list_len_ff   <= list_len_in;
         list_count_ff <= list_count_in;
         acc_ff        <= acc_in;
         decided_ff    <= decided_in;
      end
   end

endmodule

// ===== src/ssh_kex_out_stage.sv =====
`timescale 1ns / 1ps

module ssh_kex_out_stage (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load,
   input  ssh_kex_pkg::verdict_type  verdict,
   output logic                      room,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output ssh_kex_pkg::verdict_type  rsp_verdict
);
   import ssh_kex_pkg::*;

   logic        valid_ff;
   logic        valid_in;
   verdict_type verdict_ff;

   // room when empty or when the held result leaves this cycle
   assign room        = !valid_ff || rsp_ready;
   assign rsp_valid   = valid_ff;
   assign rsp_verdict = verdict_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (load) begin
         verdict_ff <= verdict;
      end
   end

endmodule

// ===== src/ssh_kexinit_packet_checker_unit.sv =====
`timescale 1ns / 1ps

// SSH2 KEXINIT packet checker for the server-to-client byte stream.
// Request channel (req_): one stream byte per request in tdata, tlast set
// when that byte ends its TCP segment.
// Response channel (rsp_): one verdict per request, in request order:
// pending, match, no match, or ignored once a verdict has been given.
// Configuration: csr_wr_en writes the packet length limit (length field
// plus four) from csr_wr_data; write it only while the block is idle.
// The input register holds an accepted request and feeds the parse step,
// which updates the parser state and loads the response register at a
// clock edge when the response register has room.
// Throughput is one request per cycle while responses are taken.
// Reset clears the parser to the start of a packet, empties both registers
// and restores the limit to 35000.
// When rsp_tready is low the response register holds its verdict, the input
// register takes one more request only if it is empty, and req_tready then
// stays low until the response is taken.
module ssh_kexinit_packet_checker_unit #(
   parameter int unsigned NAME_LIST_COUNT = ssh_kex_pkg::NameListCountDefault
) (
   input  logic        clock,
   input  logic        reset,
   // request
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] data_byte
   input  logic        req_tlast,    // segment_end
   // response
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,    // [1:0] verdict, [7:2] zero
   // configuration
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data   // max_packet_len
);
   import ssh_kex_pkg::*;

   logic [MaxLenWidth-1:0] max_len_ff;
   req_item_type           req_item;
   req_item_type           item;
   logic                   step_en;
   logic                   room;
   verdict_type            verdict;
   verdict_type            rsp_verdict;

   // packet length limit
   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MaxPacketLenReset;
      end else if (csr_wr_en) begin
         max_len_ff <= csr_wr_data;
      end
   end

   assign req_item.data_byte   = req_tdata;
   assign req_item.segment_end = req_tlast;

   ssh_kex_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_item   (req_item),
      .down_ready (room),
      .step_en    (step_en),
      .item       (item)
   );

   ssh_kex_parser #(
      .NAME_LIST_COUNT (NAME_LIST_COUNT)
   ) u_parser (
      .clock          (clock),
      .reset          (reset),
      .step_en        (step_en),
      .item           (item),
      .max_packet_len (max_len_ff),
      .verdict        (verdict)
   );

   ssh_kex_out_stage u_out_stage (
      .clock       (clock),
      .reset       (reset),
      .load        (step_en),
      .verdict     (verdict),
      .room        (room),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_verdict (rsp_verdict)
   );

   assign rsp_tdata = {6'd0, rsp_verdict};

endmodule
